// ----- rtl/pvtt_pkg.sv -----
// ----------------------------------------------------------------------------
// pvtt_pkg
// Shared types and constants of the percent variable template tokenizer.
// ----------------------------------------------------------------------------
package pvtt_pkg;

  localparam int unsigned MaxTemplateLenDef = 4096;
  localparam int unsigned QueueDepth        = 4;

  localparam int unsigned CharW     = 8;
  localparam int unsigned KindW     = 2;
  localparam int unsigned SegStartW = 12;
  localparam int unsigned SegLenW   = 13;
  localparam int unsigned ErrCodeW  = 3;

  localparam logic [CharW-1:0] ChPercent   = 8'h25;
  localparam logic [CharW-1:0] ChLParen    = 8'h28;
  localparam logic [CharW-1:0] ChLBracket  = 8'h5B;
  localparam logic [CharW-1:0] ChComma     = 8'h2C;
  localparam logic [CharW-1:0] ChRBracket  = 8'h5D;
  localparam logic [CharW-1:0] ChQuote     = 8'h22;
  localparam logic [CharW-1:0] ChBackslash = 8'h5C;
  localparam logic [CharW-1:0] ChRParen    = 8'h29;

  typedef enum logic [KindW-1:0] {
    KIND_NONE     = 2'd0,
    KIND_LITERAL  = 2'd1,
    KIND_VARIABLE = 2'd2,
    KIND_ERROR    = 2'd3
  } pvtt_kind_e;

  typedef enum logic [ErrCodeW-1:0] {
    ERR_LONE_PERCENT       = 3'd0,
    ERR_NO_BRACKET         = 3'd1,
    ERR_NO_SEPARATOR       = 3'd2,
    ERR_NO_QUOTE           = 3'd3,
    ERR_DANGLING_BACKSLASH = 3'd4,
    ERR_NO_PAREN           = 3'd5,
    ERR_NO_CLOSE           = 3'd6,
    ERR_UNTERMINATED       = 3'd7
  } pvtt_err_e;

  typedef struct packed {
    pvtt_kind_e           kind;
    logic [SegStartW-1:0] start;
    logic [SegLenW-1:0]   length;
    pvtt_err_e            code;
    logic                 done;
    logic                 last;
  } pvtt_result_t;

  // All results caused by one character: one or two.
  typedef struct packed {
    logic         two;
    pvtt_result_t first;
    pvtt_result_t second;
  } pvtt_item_t;

  function automatic logic is_space(logic [CharW-1:0] c);
    return (c == 8'd32) || (c inside {[8'd9:8'd13]});
  endfunction

endpackage

// ----- rtl/pvtt_if.sv -----
// ----------------------------------------------------------------------------
// pvtt_if
// Valid/ready channels for template characters and tokenizer results.
// ----------------------------------------------------------------------------
interface pvtt_in_if
  import pvtt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_template;

  modport source (output valid, output char_code, output end_of_template, input ready);
  modport sink (input valid, input char_code, input end_of_template, output ready);
endinterface

interface pvtt_out_if
  import pvtt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [KindW-1:0]     event_kind;
  logic [SegStartW-1:0] segment_start;
  logic [SegLenW-1:0]   segment_length;
  logic [ErrCodeW-1:0]  error_code;
  logic                 template_done;
  logic                 last_of_run;

  modport source (
    output valid, output event_kind, output segment_start, output segment_length,
    output error_code, output template_done, output last_of_run, input ready
  );
  modport sink (
    input valid, input event_kind, input segment_start, input segment_length,
    input error_code, input template_done, input last_of_run, output ready
  );
endinterface

// ----- rtl/pvtt_front.sv -----
// ----------------------------------------------------------------------------
// pvtt_front
// Parser front end: takes one character per cycle while its item is taken,
// tracks the parse state and builds the results that the character causes.
// ----------------------------------------------------------------------------
module pvtt_front
  import pvtt_pkg::*;
#(
  parameter int unsigned MaxTemplateLen = MaxTemplateLenDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pvtt_in_if.sink      in_i,
  output logic         item_valid_o,
  output pvtt_item_t   item_o,
  input  logic         item_ready_i
);

  localparam int unsigned PW = $clog2(MaxTemplateLen + 1);
  localparam int unsigned WW = (PW > SegLenW) ? PW : SegLenW;
  localparam logic [PW-1:0] MaxPos  = PW'(MaxTemplateLen);
  localparam logic [PW-1:0] LastPos = PW'(MaxTemplateLen - 1);

  localparam logic [2:0] M_LIT    = 3'd0;
  localparam logic [2:0] M_NAME   = 3'd1;
  localparam logic [2:0] M_ARR    = 3'd2;
  localparam logic [2:0] M_STR0   = 3'd3;
  localparam logic [2:0] M_STR    = 3'd4;
  localparam logic [2:0] M_DELIM  = 3'd5;
  localparam logic [2:0] M_ARGEND = 3'd6;
  localparam logic [2:0] M_VAREND = 3'd7;

  function automatic logic [PW-1:0] sat_sub(logic [PW-1:0] a, logic [PW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [SegStartW-1:0] fit_start(logic [PW-1:0] s);
    logic [PW-1:0] clipped;
    logic [WW-1:0] w;
    clipped = (s < LastPos) ? s : LastPos;
    w = WW'(clipped);
    return w[SegStartW-1:0];
  endfunction

  function automatic logic [SegLenW-1:0] fit_len(logic [PW-1:0] l);
    logic [WW-1:0] w;
    w = WW'(l);
    return w[SegLenW-1:0];
  endfunction

  logic [2:0]       mode_q, mode_d;
  logic             pct_q, pct_d;
  logic             bsl_q, bsl_d;
  logic             err_q, err_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [PW-1:0]    begin_q, begin_d;

  logic [CharW-1:0] c;
  logic             eot;
  logic             accept;
  logic [PW-1:0]    p, p_plus1, p_minus1, ll, tl;

  logic             has_a, has_b, err;
  pvtt_kind_e       a_kind;
  logic [PW-1:0]    a_start, a_len;
  pvtt_err_e        ecode;
  logic [PW-1:0]    estart, elen;
  pvtt_result_t     res_a, res_b;

  assign c        = in_i.char_code;
  assign eot      = in_i.end_of_template;
  assign in_i.ready = item_ready_i;
  assign accept   = in_i.valid && item_ready_i;

  assign p        = (pos_q < MaxPos) ? pos_q : LastPos;
  assign p_plus1  = p + 1'b1;
  assign p_minus1 = (p != '0) ? p - 1'b1 : '0;
  assign ll       = sat_sub(p_minus1, begin_q);

  always_comb begin
    mode_d  = mode_q;
    pct_d   = pct_q;
    bsl_d   = bsl_q;
    begin_d = begin_q;
    has_a   = 1'b0;
    a_kind  = KIND_NONE;
    a_start = begin_q;
    a_len   = '0;
    err     = 1'b0;
    ecode   = ERR_LONE_PERCENT;
    estart  = begin_q;
    elen    = sat_sub(p, begin_q);
    tl      = '0;

    if (!err_q) begin
      if (bsl_q) begin
        bsl_d = 1'b0;
      end else if (mode_q == M_LIT) begin
        if (pct_q) begin
          pct_d = 1'b0;
          if (c != ChPercent) begin
            if (ll != '0) begin
              has_a   = 1'b1;
              a_kind  = KIND_LITERAL;
              a_start = begin_q;
              a_len   = ll;
            end
            begin_d = p;
            mode_d  = (c == ChLParen) ? M_ARR : M_NAME;
          end
        end else if (c == ChPercent) begin
          if (eot) begin
            err    = 1'b1;
            ecode  = ERR_LONE_PERCENT;
            estart = p;
            elen   = PW'(1);
          end else begin
            pct_d = 1'b1;
          end
        end
      end else begin
        case (mode_q)
          M_NAME: begin
            if (c == ChPercent) begin
              has_a   = 1'b1;
              a_kind  = KIND_VARIABLE;
              a_start = begin_q;
              a_len   = sat_sub(p, begin_q);
              begin_d = p_plus1;
              mode_d  = M_LIT;
            end else if (c == ChLParen) begin
              mode_d = M_ARR;
            end
          end
          M_ARR: begin
            if (c == ChLBracket) begin
              mode_d = M_STR0;
            end else if (!is_space(c)) begin
              err   = 1'b1;
              ecode = ERR_NO_BRACKET;
            end
          end
          M_DELIM: begin
            if (c == ChComma) begin
              mode_d = M_STR0;
            end else if (c == ChRBracket) begin
              mode_d = M_ARGEND;
            end else if (!is_space(c)) begin
              err   = 1'b1;
              ecode = ERR_NO_SEPARATOR;
            end
          end
          M_STR0: begin
            if (c == ChQuote) begin
              mode_d = M_STR;
            end else if (!is_space(c)) begin
              err   = 1'b1;
              ecode = ERR_NO_QUOTE;
            end
          end
          M_STR: begin
            if (c == ChBackslash) begin
              if (eot) begin
                err   = 1'b1;
                ecode = ERR_DANGLING_BACKSLASH;
              end else begin
                bsl_d = 1'b1;
              end
            end else if (c == ChQuote) begin
              mode_d = M_DELIM;
            end
          end
          M_ARGEND: begin
            if (c == ChRParen) begin
              mode_d = M_VAREND;
            end else if (!is_space(c)) begin
              err   = 1'b1;
              ecode = ERR_NO_PAREN;
            end
          end
          default: begin
            if (c == ChPercent) begin
              has_a   = 1'b1;
              a_kind  = KIND_VARIABLE;
              a_start = begin_q;
              a_len   = sat_sub(p, begin_q);
              begin_d = p_plus1;
              mode_d  = M_LIT;
            end else if (!is_space(c)) begin
              err   = 1'b1;
              ecode = ERR_NO_CLOSE;
            end
          end
        endcase
      end

      if (!err && eot) begin
        if (mode_d != M_LIT) begin
          err    = 1'b1;
          ecode  = ERR_UNTERMINATED;
          estart = begin_d;
          elen   = sat_sub(p_plus1, begin_d);
        end else begin
          tl = sat_sub(p_plus1, begin_d);
        end
      end
    end

    has_b = !err_q && (err || (eot && (tl != '0)));

    res_a.kind   = a_kind;
    res_a.start  = fit_start(a_start);
    res_a.length = fit_len(a_len);
    res_a.code   = ERR_LONE_PERCENT;
    res_a.done   = !has_b && (eot || err);
    res_a.last   = !has_b;

    res_b.kind   = err ? KIND_ERROR : KIND_LITERAL;
    res_b.start  = fit_start(err ? estart : begin_d);
    res_b.length = fit_len(err ? elen : tl);
    res_b.code   = err ? ecode : ERR_LONE_PERCENT;
    res_b.done   = 1'b1;
    res_b.last   = 1'b1;

    err_d = err_q | err;
    pos_d = (pos_q < MaxPos) ? pos_q + 1'b1 : pos_q;
    if (eot) begin
      mode_d  = M_LIT;
      pct_d   = 1'b0;
      bsl_d   = 1'b0;
      err_d   = 1'b0;
      pos_d   = '0;
      begin_d = '0;
    end
  end

  assign item_valid_o = in_i.valid && (has_a || has_b);
  assign item_o.two    = has_a && has_b;
  assign item_o.first  = has_a ? res_a : res_b;
  assign item_o.second = res_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_LIT;
      pct_q   <= 1'b0;
      bsl_q   <= 1'b0;
      err_q   <= 1'b0;
      pos_q   <= '0;
      begin_q <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pct_q   <= pct_d;
      bsl_q   <= bsl_d;
      err_q   <= err_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
    end
  end

endmodule

// ----- rtl/pvtt_queue.sv -----
// ----------------------------------------------------------------------------
// pvtt_queue
// Short first-in first-out queue of result groups between front and back.
// ----------------------------------------------------------------------------
module pvtt_queue
  import pvtt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_valid_i,
  input  pvtt_item_t wr_item_i,
  output logic       wr_ready_o,
  output logic       rd_valid_o,
  output pvtt_item_t rd_item_o,
  input  logic       rd_pop_i
);

  localparam int unsigned AW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  pvtt_item_t    mem_q [QueueDepth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          push, pop;

  assign wr_ready_o = (count_q != CW'(QueueDepth));
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/pvtt_back.sv -----
// ----------------------------------------------------------------------------
// pvtt_back
// Output stage: splits each result group into words and holds the current
// word in an output register until it is taken.
// ----------------------------------------------------------------------------
module pvtt_back
  import pvtt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  pvtt_item_t  item_i,
  output logic        item_pop_o,
  pvtt_out_if.source  out_o
);

  logic         valid_q, valid_d;
  logic         half_q, half_d;
  pvtt_result_t res_q, res_d;
  logic         load;

  assign load = !valid_q || out_o.ready;

  always_comb begin
    valid_d    = valid_q;
    half_d     = half_q;
    res_d      = res_q;
    item_pop_o = 1'b0;
    if (load) begin
      valid_d = item_valid_i;
      if (item_valid_i) begin
        res_d = half_q ? item_i.second : item_i.first;
        if (item_i.two && !half_q) begin
          half_d = 1'b1;
        end else begin
          half_d     = 1'b0;
          item_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid          = valid_q;
  assign out_o.event_kind     = res_q.kind;
  assign out_o.segment_start  = res_q.start;
  assign out_o.segment_length = res_q.length;
  assign out_o.error_code     = res_q.code;
  assign out_o.template_done  = res_q.done;
  assign out_o.last_of_run    = res_q.last;

endmodule

// ----- rtl/percent_variable_template_tokenizer.sv -----
// ----------------------------------------------------------------------------
// percent_variable_template_tokenizer
// Splits a header template into literal and percent variable segments.
// ----------------------------------------------------------------------------
// The block takes one template character per cycle and reports each literal
// segment, each %NAME% or %NAME(["arg",...])% segment and the first syntax
// error of a template as a word carrying a start position and a raw length.
// Most characters cause no word or one word; a character that causes two
// words holds the output register for both in turn, and a four-entry queue
// between the parser and the output stage absorbs that and any output stall,
// so input is accepted every cycle while the queue has room. A word passes
// through the queue and then the output register before it reaches the output.
module percent_variable_template_tokenizer
  import pvtt_pkg::*;
#(
  parameter int unsigned MaxTemplateLen = MaxTemplateLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pvtt_in_if.sink    in_i,
  pvtt_out_if.source out_o
);

  logic       wr_valid, wr_ready, rd_valid, rd_pop;
  pvtt_item_t wr_item, rd_item;

  pvtt_front #(
    .MaxTemplateLen(MaxTemplateLen)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (wr_valid),
    .item_o       (wr_item),
    .item_ready_i (wr_ready)
  );

  pvtt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_item_i  (wr_item),
    .wr_ready_o (wr_ready),
    .rd_valid_o (rd_valid),
    .rd_item_o  (rd_item),
    .rd_pop_i   (rd_pop)
  );

  pvtt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (rd_valid),
    .item_i       (rd_item),
    .item_pop_o   (rd_pop),
    .out_o        (out_o)
  );

endmodule

// ----- tb/sv/pvtt_checker.sv -----
// ----------------------------------------------------------------------------
// pvtt_checker
// Watches both channels of the template tokenizer, predicts the words that
// each accepted character causes and compares them with the words that the
// block delivers, in order and field by field.
// ----------------------------------------------------------------------------
module pvtt_checker
  import pvtt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pvtt_in_if   chars_i,
  pvtt_out_if  words_i,
  output int   mismatches_o,
  output int   outstanding_o,
  output int   literals_o,
  output int   variables_o,
  output int   errors_o
);

  localparam int unsigned MaxLen = MaxTemplateLenDef;

  // Words that are not errors carry a zero code.
  localparam pvtt_err_e CodeClear = ERR_LONE_PERCENT;

  typedef enum logic [2:0] {
    PM_LITERAL,
    PM_NAME,
    PM_ARRAY,
    PM_ARG_OPEN,
    PM_ARG_BODY,
    PM_ARG_DELIM,
    PM_ARG_END,
    PM_VAR_END
  } parse_mode_e;

  parse_mode_e  mode;
  logic         pct_pending;
  logic         esc_pending;
  logic         err_latched;
  int unsigned  char_pos;
  int unsigned  seg_begin;
  pvtt_result_t pending_words[$];

  function automatic int unsigned clip_sub(int unsigned a, int unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic logic is_blank(logic [CharW-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic pvtt_result_t make_word(pvtt_kind_e kind, int unsigned start,
                                             int unsigned len, pvtt_err_e code);
    pvtt_result_t w;
    w.kind   = kind;
    w.start  = SegStartW'((start < MaxLen - 1) ? start : MaxLen - 1);
    w.length = SegLenW'(len);
    w.code   = code;
    w.done   = 1'b0;
    w.last   = 1'b0;
    return w;
  endfunction

  function automatic string word_text(pvtt_result_t w);
    return $sformatf("kind %0d start %0d length %0d code %0d done %0b last %0b",
                     w.kind, w.start, w.length, w.code, w.done, w.last);
  endfunction

  function automatic void clear_state();
    mode        = PM_LITERAL;
    pct_pending = 1'b0;
    esc_pending = 1'b0;
    err_latched = 1'b0;
    char_pos    = 0;
    seg_begin   = 0;
  endfunction

  task automatic tokenize_char(input logic [CharW-1:0] c, input logic eot);
    pvtt_result_t w [2];
    int           n;
    int unsigned  p;
    int unsigned  ll;
    logic         bad;
    pvtt_err_e    ecode;
    int unsigned  estart;
    int unsigned  elen;
    n      = 0;
    bad    = 1'b0;
    ecode  = CodeClear;
    p      = (char_pos < MaxLen) ? char_pos : MaxLen - 1;
    estart = seg_begin;
    elen   = clip_sub(p, seg_begin);
    if (!err_latched) begin
      if (esc_pending) begin
        esc_pending = 1'b0;
      end else if (mode == PM_LITERAL) begin
        if (pct_pending) begin
          pct_pending = 1'b0;
          if (c != ChPercent) begin
            ll = clip_sub(clip_sub(p, 1), seg_begin);
            if (ll > 0) begin
              w[n] = make_word(KIND_LITERAL, seg_begin, ll, CodeClear);
              n++;
            end
            seg_begin = p;
            mode = (c == ChLParen) ? PM_ARRAY : PM_NAME;
          end
        end else if (c == ChPercent) begin
          if (eot) begin
            bad    = 1'b1;
            ecode  = ERR_LONE_PERCENT;
            estart = p;
            elen   = 1;
          end else begin
            pct_pending = 1'b1;
          end
        end
      end else if ((mode == PM_NAME || mode == PM_VAR_END) && c == ChPercent) begin
        w[n] = make_word(KIND_VARIABLE, seg_begin, clip_sub(p, seg_begin), CodeClear);
        n++;
        seg_begin = p + 1;
        mode = PM_LITERAL;
      end else begin
        case (mode)
          PM_NAME: begin
            if (c == ChLParen) mode = PM_ARRAY;
          end
          PM_ARRAY: begin
            if (c == ChLBracket) mode = PM_ARG_OPEN;
            else if (!is_blank(c)) begin
              bad   = 1'b1;
              ecode = ERR_NO_BRACKET;
            end
          end
          PM_ARG_DELIM: begin
            if (c == ChComma) mode = PM_ARG_OPEN;
            else if (c == ChRBracket) mode = PM_ARG_END;
            else if (!is_blank(c)) begin
              bad   = 1'b1;
              ecode = ERR_NO_SEPARATOR;
            end
          end
          PM_ARG_OPEN: begin
            if (c == ChQuote) mode = PM_ARG_BODY;
            else if (!is_blank(c)) begin
              bad   = 1'b1;
              ecode = ERR_NO_QUOTE;
            end
          end
          PM_ARG_BODY: begin
            if (c == ChBackslash) begin
              if (eot) begin
                bad   = 1'b1;
                ecode = ERR_DANGLING_BACKSLASH;
              end else begin
                esc_pending = 1'b1;
              end
            end else if (c == ChQuote) begin
              mode = PM_ARG_DELIM;
            end
          end
          PM_ARG_END: begin
            if (c == ChRParen) mode = PM_VAR_END;
            else if (!is_blank(c)) begin
              bad   = 1'b1;
              ecode = ERR_NO_PAREN;
            end
          end
          default: begin
            if (!is_blank(c)) begin
              bad   = 1'b1;
              ecode = ERR_NO_CLOSE;
            end
          end
        endcase
      end

      if (!bad && eot) begin
        if (mode != PM_LITERAL) begin
          bad    = 1'b1;
          ecode  = ERR_UNTERMINATED;
          estart = seg_begin;
          elen   = clip_sub(p + 1, seg_begin);
        end else begin
          ll = clip_sub(p + 1, seg_begin);
          if (ll > 0) begin
            w[n] = make_word(KIND_LITERAL, seg_begin, ll, CodeClear);
            n++;
          end
        end
      end

      if (bad) begin
        w[n] = make_word(KIND_ERROR, estart, elen, ecode);
        n++;
        err_latched = 1'b1;
      end

      if (n > 0) begin
        if (eot || bad) w[n-1].done = 1'b1;
        w[n-1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) pending_words.push_back(w[i]);
    end

    if (char_pos < MaxLen) char_pos++;
    if (eot) clear_state();
  endtask

  task automatic check_word();
    pvtt_result_t got;
    pvtt_result_t want;
    got.kind   = pvtt_kind_e'(words_i.event_kind);
    got.start  = words_i.segment_start;
    got.length = words_i.segment_length;
    got.code   = pvtt_err_e'(words_i.error_code);
    got.done   = words_i.template_done;
    got.last   = words_i.last_of_run;
    if (pending_words.size() == 0) begin
      mismatches_o++;
      if (mismatches_o <= 10) $display("Unexpected word: %s", word_text(got));
    end else begin
      want = pending_words.pop_front();
      case (want.kind)
        KIND_LITERAL:  literals_o++;
        KIND_VARIABLE: variables_o++;
        default:       errors_o++;
      endcase
      if (got !== want) begin
        mismatches_o++;
        if (mismatches_o <= 10) begin
          $display("Word mismatch: expected %s", word_text(want));
          $display("                 actual %s", word_text(got));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      pending_words.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
      literals_o    = 0;
      variables_o   = 0;
      errors_o      = 0;
    end else begin
      if (chars_i.valid && chars_i.ready) begin
        tokenize_char(chars_i.char_code, chars_i.end_of_template);
      end
      if (words_i.valid && words_i.ready) check_word();
      outstanding_o = pending_words.size();
    end
  end

endmodule

// ----- tb/sv/percent_variable_template_tokenizer_tb.sv -----
// ----------------------------------------------------------------------------
// percent_variable_template_tokenizer_tb
// Feeds the tokenizer a short set of hand-made templates and then random
// well-formed, damaged and noise templates, plus one template longer than the
// position range, with random idle cycles on both channels. A checker beside
// the block predicts and compares every word; this module gives the verdict.
// ----------------------------------------------------------------------------
module percent_variable_template_tokenizer_tb
  import pvtt_pkg::*;
;

  localparam int unsigned RandomChars = 1500;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned LongFill    = MaxTemplateLenDef - 6;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;

  logic clk_i;
  logic rst_ni;

  pvtt_in_if  chars_if ();
  pvtt_out_if words_if ();

  logic             steady;
  logic [CharW-1:0] tpl[$];
  int unsigned      n_chars;
  int unsigned      n_templates;
  int unsigned      cycles;

  int mismatches;
  int outstanding;
  int literals;
  int variables;
  int errors;

  percent_variable_template_tokenizer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (chars_if),
    .out_o  (words_if)
  );

  pvtt_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .chars_i       (chars_if),
    .words_i       (words_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .literals_o    (literals),
    .variables_o   (variables),
    .errors_o      (errors)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Cycle limit of %0d reached with %0d words outstanding.", CycleLimit,
               outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [CharW-1:0] blank_byte();
    if ($urandom_range(0, 5) == 0) return ChSpace;
    return CharW'($urandom_range(ChTab, ChCr));
  endfunction

  function automatic logic [CharW-1:0] plain_byte();
    logic [CharW-1:0] b;
    do b = CharW'($urandom_range(0, 255)); while (b == ChPercent);
    return b;
  endfunction

  function automatic logic [CharW-1:0] name_byte();
    logic [CharW-1:0] b;
    if ($urandom_range(0, 3) != 0) return CharW'($urandom_range(8'h61, 8'h7A));
    do b = CharW'($urandom_range(0, 255)); while (b == ChPercent || b == ChLParen);
    return b;
  endfunction

  function automatic logic [CharW-1:0] special_byte();
    case ($urandom_range(0, 10))
      0:       return ChPercent;
      1:       return ChLParen;
      2:       return ChLBracket;
      3:       return ChComma;
      4:       return ChRBracket;
      5:       return ChQuote;
      6:       return ChBackslash;
      7:       return ChRParen;
      8:       return blank_byte();
      default: return CharW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) tpl.push_back(s[i]);
  endtask

  task automatic add_blanks();
    repeat ($urandom_range(0, 2)) tpl.push_back(blank_byte());
  endtask

  task automatic add_literal();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 7) == 0) begin
        tpl.push_back(ChPercent);
        tpl.push_back(ChPercent);
      end else begin
        tpl.push_back(plain_byte());
      end
    end
  endtask

  task automatic add_quoted();
    logic [CharW-1:0] b;
    tpl.push_back(ChQuote);
    repeat ($urandom_range(0, 5)) begin
      b = CharW'($urandom_range(0, 255));
      if (b == ChQuote || b == ChBackslash) tpl.push_back(ChBackslash);
      tpl.push_back(b);
    end
    tpl.push_back(ChQuote);
  endtask

  task automatic add_variable();
    logic        with_args;
    int unsigned args;
    with_args = $urandom_range(0, 1);
    tpl.push_back(ChPercent);
    repeat ($urandom_range(with_args ? 0 : 1, 4)) tpl.push_back(name_byte());
    if (with_args) begin
      args = $urandom_range(1, 3);
      tpl.push_back(ChLParen);
      add_blanks();
      tpl.push_back(ChLBracket);
      for (int i = 0; i < args; i++) begin
        if (i > 0) tpl.push_back(ChComma);
        add_blanks();
        add_quoted();
        add_blanks();
      end
      tpl.push_back(ChRBracket);
      add_blanks();
      tpl.push_back(ChRParen);
      add_blanks();
    end
    tpl.push_back(ChPercent);
  endtask

  task automatic build_wellformed();
    tpl = {};
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1)) add_literal();
      else add_variable();
    end
  endtask

  // Damages a template by overwriting a character, inserting one, or cutting it short.
  task automatic break_template();
    int unsigned at;
    at = $urandom_range(0, tpl.size() - 1);
    case ($urandom_range(0, 2))
      0:       tpl[at] = special_byte();
      1:       tpl.insert(at, special_byte());
      default: while (tpl.size() > at + 1) void'(tpl.pop_back());
    endcase
  endtask

  task automatic drive_char(input logic [CharW-1:0] c, input logic eot,
                            input int unsigned gap);
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    chars_if.valid           <= 1'b1;
    chars_if.char_code       <= c;
    chars_if.end_of_template <= eot;
    @(posedge clk_i);
    while (!chars_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_template();
    for (int i = 0; i < tpl.size(); i++) begin
      drive_char(tpl[i], i == tpl.size() - 1, steady ? 0 : $urandom_range(0, 10));
    end
    n_templates++;
    n_chars += tpl.size();
  endtask

  // Result side: after each word taken, hold ready low for a random stall.
  initial begin
    int unsigned hold;
    hold = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        words_if.ready <= 1'b0;
        hold--;
      end else begin
        words_if.ready <= 1'b1;
        @(posedge clk_i);
        if (words_if.valid) hold = steady ? 0 : $urandom_range(0, 10);
      end
    end
  end

  initial begin
    int unsigned n_random;
    int unsigned pick;
    logic        long_done;
    rst_ni                   = 1'b0;
    chars_if.valid           = 1'b0;
    chars_if.char_code       = '0;
    chars_if.end_of_template = 1'b0;
    words_if.ready           = 1'b0;
    steady                   = 1'b0;
    n_chars                  = 0;
    n_templates              = 0;
    n_random                 = 0;
    long_done                = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Lone percent as the whole template.
    tpl = {};
    push_text("%");
    send_template();
    // A literal whose closing percent opens a variable on the final character.
    tpl = {};
    push_text("a%(");
    send_template();
    // Extreme byte values around an escaped percent.
    tpl = {8'h00, ChPercent, ChPercent, 8'hFF};
    send_template();
    tpl = {};
    push_text("%a%");
    send_template();
    // Missing quote, then a character that must be ignored.
    tpl = {};
    push_text("%([x!");
    send_template();
    tpl = {};
    push_text("%([\"\\");
    send_template();

    while (n_random < RandomChars) begin
      if (!long_done && n_random > RandomChars / 2) begin
        // Runs positions into saturation, then ends in a literal and an error.
        tpl = {};
        repeat (LongFill) tpl.push_back(plain_byte());
        push_text("%ab%xyz%(");
        steady    = 1'b1;
        long_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          build_wellformed();
        end else if (pick < 17) begin
          build_wellformed();
          break_template();
        end else begin
          tpl = {};
          repeat ($urandom_range(1, 12)) tpl.push_back(special_byte());
        end
        steady = ($urandom_range(0, 4) == 0);
        n_random += tpl.size();
      end
      send_template();
    end

    chars_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d characters in %0d templates, one of them past %0d positions.",
             n_chars, n_templates, MaxTemplateLenDef);
    $display("Compared %0d literal, %0d variable and %0d error words; %0d mismatches.",
             literals, variables, errors, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
